// ===== hw/rtl/utf8cp_pkg.sv =====
// Shared types and byte constants for the UTF-8 to CP866 transcoder.
package utf8cp_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 2;

    // Lead and prefix bytes of the recognized UTF-8 sequences.
    localparam logic [BYTE_W-1:0] LEAD_D0     = 8'hD0;
    localparam logic [BYTE_W-1:0] LEAD_D1     = 8'hD1;
    localparam logic [BYTE_W-1:0] LEAD_C2     = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD_E2     = 8'hE2;
    localparam logic [BYTE_W-1:0] PREFIX_86   = 8'h86;

    // Follower bytes and their CP866 codes.
    localparam logic [BYTE_W-1:0] FOL_IO_UP   = 8'h81;
    localparam logic [BYTE_W-1:0] CP_IO_UP    = 8'hF0;
    localparam logic [BYTE_W-1:0] FOL_IO_LOW  = 8'h91;
    localparam logic [BYTE_W-1:0] CP_IO_LOW   = 8'hF1;
    localparam logic [BYTE_W-1:0] FOL_CURR    = 8'hA4;
    localparam logic [BYTE_W-1:0] CP_CURR     = 8'hFD;
    localparam logic [BYTE_W-1:0] CP_QUESTION = 8'h3F;

    // Follower ranges for the two Cyrillic leads.
    localparam logic [BYTE_W-1:0] D0_RANGE_LO = 8'h90;
    localparam logic [BYTE_W-1:0] D0_RANGE_HI = 8'hBF;
    localparam logic [BYTE_W-1:0] D0_OFFSET   = 8'h10;
    localparam logic [BYTE_W-1:0] D1_RANGE_LO = 8'h80;
    localparam logic [BYTE_W-1:0] D1_RANGE_HI = 8'h8F;
    localparam logic [BYTE_W-1:0] D1_OFFSET   = 8'h60;

    // Number of output slots.
    localparam logic [CNT_W-1:0] BUF_DEPTH = 2'd2;

    // What one decoded input byte releases: zero, one or two bytes.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
    } dec_res_t;

    // One buffered result.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_ent_t;

endpackage

// ===== hw/rtl/utf8cp_decode.sv =====
// Sequence decoder: pending-lead mode register and the byte translation logic.
module utf8cp_decode
    import utf8cp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] cur_byte,
    input  logic              cur_last,
    input  logic              advance,
    output dec_res_t          res
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_D0,
        MODE_D1,
        MODE_C2,
        MODE_E2,
        MODE_E286
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;

    function automatic logic [BYTE_W-1:0] arrow_code(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        unique case (b)
            8'h96:   r = 8'h1C;
            8'h91:   r = 8'h18;
            8'h90:   r = 8'h1B;
            8'h93:   r = 8'h19;
            8'h92:   r = 8'h1A;
            default: r = CP_QUESTION;
        endcase
        return r;
    endfunction

    always_comb
    begin
        res.cnt   = '0;
        res.b0    = cur_byte;
        res.b1    = cur_byte;
        mode_next = MODE_IDLE;
        unique case (mode_reg)
            MODE_D0:
            begin
                if (cur_byte == FOL_IO_UP)
                begin
                    res.cnt = 2'd1;
                    res.b0  = CP_IO_UP;
                end
                else if (cur_byte >= D0_RANGE_LO && cur_byte <= D0_RANGE_HI)
                begin
                    res.cnt = 2'd1;
                    res.b0  = cur_byte - D0_OFFSET;
                end
            end
            MODE_D1:
            begin
                if (cur_byte == FOL_IO_LOW)
                begin
                    res.cnt = 2'd1;
                    res.b0  = CP_IO_LOW;
                end
                else if (cur_byte >= D1_RANGE_LO && cur_byte <= D1_RANGE_HI)
                begin
                    res.cnt = 2'd1;
                    res.b0  = cur_byte + D1_OFFSET;
                end
            end
            MODE_C2:
            begin
                res.cnt = 2'd1;
                res.b0  = (cur_byte == FOL_CURR) ? CP_CURR : CP_QUESTION;
            end
            MODE_E2:
            begin
                // A held E2 at the end of the string comes out raw with its follower.
                if (cur_last)
                begin
                    res.cnt = 2'd2;
                    res.b0  = LEAD_E2;
                end
                else if (cur_byte == PREFIX_86)
                begin
                    mode_next = MODE_E286;
                end
            end
            MODE_E286:
            begin
                res.cnt = 2'd1;
                res.b0  = arrow_code(cur_byte);
            end
            MODE_IDLE:
            begin
                if (!cur_last && cur_byte == LEAD_D0)
                begin
                    mode_next = MODE_D0;
                end
                else if (!cur_last && cur_byte == LEAD_D1)
                begin
                    mode_next = MODE_D1;
                end
                else if (!cur_last && cur_byte == LEAD_C2)
                begin
                    mode_next = MODE_C2;
                end
                else if (!cur_last && cur_byte == LEAD_E2)
                begin
                    mode_next = MODE_E2;
                end
                else
                begin
                    res.cnt = 2'd1;
                end
            end
            default:
            begin
                res.cnt = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
        end
    end

    // The end of a string always leaves the decoder idle.
    a_last_clears_mode: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cur_last |=> mode_reg == MODE_IDLE)
        else $error("mode still pending after last byte");

    // Only a held E2 can release two bytes.
    a_two_only_from_e2: assert property (@(posedge clk) disable iff (!rst_n)
        res.cnt == 2'd2 |-> mode_reg == MODE_E2 && cur_last)
        else $error("two results outside E2 end case");

    // A lead byte that is held never produces a result in the same step.
    a_hold_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        mode_next != MODE_IDLE |-> res.cnt == 2'd0)
        else $error("result produced while holding a lead byte");

endmodule

// ===== hw/rtl/utf8cp_outbuf.sv =====
// Two-slot result buffer that takes up to two bytes per cycle and drains one.
module utf8cp_outbuf
    import utf8cp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dec_res_t          push_res,
    output logic [CNT_W-1:0]  free_cnt,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last,
    output logic              out_valid,
    input  logic              out_ready
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    out_ent_t         ent_reg  [2];
    out_ent_t         ent_next [2];

    logic             pop;
    logic [CNT_W-1:0] rem;
    logic [CNT_W-1:0] push_cnt;
    out_ent_t         pe0;
    out_ent_t         pe1;
    out_ent_t         head_shift;

    assign out_valid = (count_reg != '0);
    assign out_byte  = ent_reg[0].data;
    assign run_last  = ent_reg[0].last;
    assign free_cnt  = BUF_DEPTH - count_reg;

    always_comb
    begin
        pop        = out_valid && out_ready;
        rem        = count_reg - {{(CNT_W-1){1'b0}}, pop};
        push_cnt   = push ? push_res.cnt : '0;
        // The first of two released bytes is not the last one.
        pe0.data   = push_res.b0;
        pe0.last   = (push_res.cnt != 2'd2);
        pe1.data   = push_res.b1;
        pe1.last   = 1'b1;
        head_shift = pop ? ent_reg[1] : ent_reg[0];

        ent_next[0] = (rem != '0) ? head_shift : pe0;
        if (rem == 2'd2)
        begin
            ent_next[1] = ent_reg[1];
        end
        else if (rem == 2'd1)
        begin
            ent_next[1] = pe0;
        end
        else
        begin
            ent_next[1] = pe1;
        end
        count_next = rem + push_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= BUF_DEPTH)
        else $error("result buffer count out of range");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_res.cnt <= free_cnt)
        else $error("push overflows result buffer");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_res.cnt == 2'd2 |=> out_valid && !run_last && count_reg == 2'd2)
        else $error("two-byte release not queued in order");

endmodule

// ===== hw/rtl/utf8_to_cp866_transcoder.sv =====
// UTF-8 to CP866 byte-stream transcoder, top level.
// One UTF-8 byte is taken per clock with a valid/ready transfer. The byte is
// registered, decoded against the pending-lead mode register, and the zero,
// one or two CP866 bytes it releases are written into a two-slot result
// buffer. Throughput is one byte per clock while the consumer keeps up. The
// only byte that releases two results is the one after a held 0xE2 that
// ends the string; it needs both buffer slots empty, so it waits until
// earlier results have drained. Lead bytes that are held and dropped
// sequences give no result; run_last marks the final result caused by each
// input byte.
module utf8_to_cp866_transcoder
    import utf8cp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last
);

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_fire;
    logic [CNT_W-1:0]  free_cnt;
    dec_res_t          dec_res;

    assign s1_fire  = s1_valid_reg && (dec_res.cnt <= free_cnt);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    utf8cp_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cur_byte (s1_byte_reg),
        .cur_last (s1_last_reg),
        .advance  (s1_fire),
        .res      (dec_res)
    );

    utf8cp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_fire),
        .push_res  (dec_res),
        .free_cnt  (free_cnt),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // A byte in the input register that is blocked keeps its payload.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_byte_reg)
            && $stable(s1_last_reg))
        else $error("input stage lost a blocked byte");

    // A single-result byte is never blocked while the buffer has room.
    a_single_flows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && dec_res.cnt != 2'd2 && free_cnt != '0 |-> s1_fire)
        else $error("input stage stalled with buffer space free");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("not ready with empty input stage");

endmodule
